[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge while not in reset.
`define ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

[hw/rtl/csrspmv_pkg.sv]
// ----------------------------------------------------------------------------
// csrspmv_pkg
// Shared types, operation codes and sizes of the normalized CSR SpMV block.
// ----------------------------------------------------------------------------
package csrspmv_pkg;
    localparam int MAX_ROWS_DEF     = 1024;
    localparam int MAX_NONZEROS_DEF = 4096;

    localparam logic [2:0] OP_LOAD_VEC = 3'd0;
    localparam logic [2:0] OP_LOAD_PTR = 3'd1;
    localparam logic [2:0] OP_LOAD_NZ  = 3'd2;
    localparam logic [2:0] OP_COMPUTE  = 3'd3;
    localparam logic [2:0] OP_READ     = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ROW_START,
        S_ROW_END,
        S_NZ_ADDR,
        S_NZ_VEC,
        S_NZ_MAC,
        S_ROW_DONE,
        S_COMP_DONE,
        S_RD_FETCH,
        S_RD_DIV,
        S_RD_DONE
    } t_state;

    typedef struct packed {
        logic load_vec;
        logic load_ptr;
        logic load_nz;
        logic cmp_init;
        logic ptr_rd_start;
        logic ptr_rd_end;
        logic nz_rd;
        logic vec_rd;
        logic mac;
        logic row_store;
        logic total_store;
        logic rd_fetch;
        logic div_start;
        logic div_step;
        logic emit_cmp;
        logic emit_rd;
    } t_cmd;

    typedef struct packed {
        logic row_last;
        logic nz_last;
        logic row_empty;
        logic div_done;
    } t_status;
endpackage

[hw/rtl/csrspmv_ctrl.sv]
// ----------------------------------------------------------------------------
// csrspmv_ctrl
// Sequencer for loads, the compute walk and the read divide.
// ----------------------------------------------------------------------------
module csrspmv_ctrl
    import csrspmv_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  logic [2:0] i_operation,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_busy
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_operation == OP_COMPUTE) begin
                        n_state = i_status.row_last ? S_COMP_DONE : S_ROW_START;
                    end else if (i_operation == OP_READ) begin
                        n_state = S_RD_FETCH;
                    end
                end
            end
            S_ROW_START: n_state = S_ROW_END;
            S_ROW_END:   n_state = S_NZ_ADDR;
            S_NZ_ADDR:   n_state = i_status.row_empty ? S_ROW_DONE : S_NZ_VEC;
            S_NZ_VEC:    n_state = S_NZ_MAC;
            S_NZ_MAC:    n_state = i_status.nz_last ? S_ROW_DONE : S_NZ_VEC;
            S_ROW_DONE:  n_state = i_status.row_last ? S_COMP_DONE : S_ROW_START;
            S_COMP_DONE: n_state = S_IDLE;
            S_RD_FETCH:  n_state = S_RD_DIV;
            S_RD_DIV:    n_state = i_status.div_done ? S_RD_DONE : S_RD_DIV;
            S_RD_DONE:   n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = (r_state != S_IDLE);
        case (r_state)
            S_IDLE: begin
                o_cmd.load_vec = i_start && (i_operation == OP_LOAD_VEC);
                o_cmd.load_ptr = i_start && (i_operation == OP_LOAD_PTR);
                o_cmd.load_nz  = i_start && (i_operation == OP_LOAD_NZ);
                o_cmd.cmp_init = i_start && (i_operation == OP_COMPUTE);
                o_cmd.rd_fetch = i_start && (i_operation == OP_READ);
            end
            S_ROW_START: o_cmd.ptr_rd_start = 1'b1;
            S_ROW_END:   o_cmd.ptr_rd_end   = 1'b1;
            S_NZ_ADDR:   o_cmd.nz_rd        = !i_status.row_empty;
            S_NZ_VEC:    o_cmd.vec_rd       = 1'b1;
            S_NZ_MAC: begin
                o_cmd.mac   = 1'b1;
                o_cmd.nz_rd = !i_status.nz_last;
            end
            S_ROW_DONE:  o_cmd.row_store = 1'b1;
            S_COMP_DONE: begin
                o_cmd.total_store = 1'b1;
                o_cmd.emit_cmp    = 1'b1;
            end
            S_RD_FETCH:  o_cmd.div_start = 1'b1;
            S_RD_DIV:    o_cmd.div_step  = 1'b1;
            S_RD_DONE:   o_cmd.emit_rd   = 1'b1;
            default: ;
        endcase
    end
endmodule

[hw/rtl/csrspmv_dp.sv]
// ----------------------------------------------------------------------------
// csrspmv_dp
// Stores, multiply-accumulate, totals and a restoring divider.
// ----------------------------------------------------------------------------
module csrspmv_dp
    import csrspmv_pkg::*;
#(
    parameter int MAX_ROWS     = MAX_ROWS_DEF,
    parameter int MAX_NONZEROS = MAX_NONZEROS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic [12:0]        i_index,
    input  logic [12:0]        i_pointer,
    input  logic [9:0]         i_column,
    input  logic signed [15:0] i_value,
    input  logic [10:0]        i_row_count,
    output t_status            o_status,
    output logic               o_done,
    output logic signed [31:0] o_normalized_value,
    output logic signed [57:0] o_total_sum,
    output logic               o_zero_sum,
    output logic               o_saturated
);
    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int PW = $clog2(MAX_ROWS + 1);
    localparam int NW = (MAX_NONZEROS > 1) ? $clog2(MAX_NONZEROS) : 1;
    localparam int DW = 74;
    localparam logic signed [47:0] R_MAX = {1'b0, {47{1'b1}}};
    localparam logic signed [47:0] R_MIN = {1'b1, {47{1'b0}}};
    localparam logic signed [57:0] T_MAX = {1'b0, {57{1'b1}}};
    localparam logic signed [57:0] T_MIN = {1'b1, {57{1'b0}}};

    logic signed [15:0] r_vec_mem [MAX_ROWS];
    logic [12:0]        r_ptr_mem [MAX_ROWS + 1];
    logic [9:0]         r_col_mem [MAX_NONZEROS];
    logic signed [15:0] r_ent_mem [MAX_NONZEROS];
    logic signed [47:0] r_res_mem [MAX_ROWS];

    logic [16:0]        r_rows, r_row;
    logic [13:0]        r_j, r_end;
    logic [9:0]         r_col;
    logic signed [15:0] r_ent, r_x;
    logic               r_col_ok;
    logic signed [47:0] r_acc;
    logic signed [57:0] r_tot_acc, r_total;
    logic signed [47:0] r_rd_res;
    logic [PW-1:0]      r_ptr_rd;
    logic               r_rd_ok;
    logic [DW-1:0]      r_rem, r_quo;
    logic [57:0]        r_den;
    logic [6:0]         r_cnt;
    logic               r_neg;
    logic               r_done;
    logic [12:0]        r_ptr_q;

    // Vector store.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_vec && (32'(i_index) < MAX_ROWS)) begin
            r_vec_mem[i_index[RW-1:0]] <= i_value;
        end
        if (i_cmd.vec_rd) begin
            r_x <= r_vec_mem[r_col[RW-1:0]];
        end
    end

    // Row pointer store with one read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_ptr && (32'(i_index) <= MAX_ROWS)) begin
            r_ptr_mem[i_index[PW-1:0]] <= i_pointer;
        end
        r_ptr_q <= r_ptr_mem[r_ptr_rd];
    end

    always_comb begin
        if (i_cmd.ptr_rd_start) begin
            r_ptr_rd = r_row[PW-1:0];
        end else begin
            r_ptr_rd = PW'(r_row + 17'd1);
        end
    end

    // Nonzero stores.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_nz && (32'(i_index) < MAX_NONZEROS)) begin
            r_col_mem[i_index[NW-1:0]] <= i_column;
            r_ent_mem[i_index[NW-1:0]] <= i_value;
        end
        if (i_cmd.nz_rd) begin
            r_col <= r_col_mem[r_j[NW-1:0]];
            r_ent <= r_ent_mem[r_j[NW-1:0]];
        end
    end

    // Row result store.
    always_ff @(posedge i_clk) begin
        if (i_cmd.row_store) begin
            r_res_mem[r_row[RW-1:0]] <= r_acc;
        end
        if (i_cmd.rd_fetch) begin
            r_rd_res <= r_res_mem[i_index[RW-1:0]];
        end
    end

    logic [13:0] n_end_clamp;
    assign n_end_clamp = (32'(r_ptr_q) > MAX_NONZEROS) ? 14'(MAX_NONZEROS) : {1'b0, r_ptr_q};

    logic signed [31:0] n_prod;
    logic signed [48:0] n_acc;
    logic signed [58:0] n_tot;
    assign n_prod = r_col_ok ? (r_x * r_ent) : 32'sd0;
    assign n_acc  = 49'(r_acc) + 49'(n_prod);
    assign n_tot  = 59'(r_tot_acc) + 59'(r_acc);

    logic [16:0] n_rows_clamp;
    assign n_rows_clamp = (32'(i_row_count) > MAX_ROWS) ? 17'(MAX_ROWS) : 17'(i_row_count);

    // Walk counters and accumulators.
    always_ff @(posedge i_clk) begin
        if (i_cmd.cmp_init) begin
            r_rows    <= n_rows_clamp;
            r_row     <= 17'd0;
            r_tot_acc <= '0;
        end
        if (i_cmd.ptr_rd_start) begin
            r_acc <= '0;
        end
        if (i_cmd.ptr_rd_end) begin
            r_j <= {1'b0, r_ptr_q};
        end
        if (o_status.row_empty == 1'b0 && i_cmd.nz_rd) begin
            r_j <= r_j + 14'd1;
        end
        if (i_cmd.vec_rd) begin
            r_col_ok <= (32'(r_col) < MAX_ROWS);
        end
        if (i_cmd.mac) begin
            if (n_acc > 49'(R_MAX)) begin
                r_acc <= R_MAX;
            end else if (n_acc < 49'(R_MIN)) begin
                r_acc <= R_MIN;
            end else begin
                r_acc <= n_acc[47:0];
            end
        end
        if (i_cmd.row_store) begin
            r_row <= r_row + 17'd1;
            if (n_tot > 59'(T_MAX)) begin
                r_tot_acc <= T_MAX;
            end else if (n_tot < 59'(T_MIN)) begin
                r_tot_acc <= T_MIN;
            end else begin
                r_tot_acc <= n_tot[57:0];
            end
        end
    end

    // The end offset arrives in the cycle after the start offset.
    logic r_end_pend;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_end_pend <= 1'b0;
        end else begin
            r_end_pend <= i_cmd.ptr_rd_end;
        end
        if (r_end_pend) begin
            r_end <= n_end_clamp;
        end
    end

    assign o_status.row_last  = i_cmd.cmp_init ? (n_rows_clamp == 17'd0)
                                                : ((r_row + 17'd1) >= r_rows);
    assign o_status.row_empty = !(r_j < n_end_clamp);
    assign o_status.nz_last   = !(r_j < r_end);

    // Total register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else if (i_cmd.total_store) begin
            r_total <= r_tot_acc;
        end
    end

    // Restoring divider, one quotient bit a cycle.
    logic [57:0] n_mag_t;
    logic [47:0] n_mag_r;
    logic [DW:0] n_trial;
    logic signed [47:0] n_rsel;
    assign n_rsel  = r_rd_ok ? r_rd_res : 48'sd0;
    assign n_mag_r = n_rsel[47] ? 48'(-n_rsel) : 48'(n_rsel);
    assign n_mag_t = r_total[57] ? 58'(-r_total) : 58'(r_total);
    assign n_trial = {r_rem[DW-2:0], r_quo[DW-1]} - {17'd0, r_den};

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_fetch) begin
            r_rd_ok <= (32'(i_index) < MAX_ROWS);
        end
        if (i_cmd.div_start) begin
            r_rem <= '0;
            r_quo <= {10'd0, n_mag_r, 16'd0};
            r_den <= n_mag_t;
            r_cnt <= 7'd0;
            r_neg <= n_rsel[47] != r_total[57];
        end
        if (i_cmd.div_step) begin
            r_cnt <= r_cnt + 7'd1;
            if (!n_trial[DW]) begin
                r_rem <= n_trial[DW-1:0];
                r_quo <= {r_quo[DW-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[DW-2:0], r_quo[DW-1]};
                r_quo <= {r_quo[DW-2:0], 1'b0};
            end
        end
    end
    assign o_status.div_done = (r_cnt == 7'(DW - 1)) && i_cmd.div_step;

    // Result register.
    logic zero_t;
    assign zero_t = (r_total == '0);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.emit_cmp || i_cmd.emit_rd;
        end
        if (i_cmd.emit_cmp) begin
            o_normalized_value <= '0;
            o_saturated        <= 1'b0;
            o_total_sum        <= r_tot_acc;
            o_zero_sum         <= (r_tot_acc == '0);
        end
        if (i_cmd.emit_rd) begin
            o_total_sum <= r_total;
            o_zero_sum  <= zero_t;
            if (zero_t) begin
                o_normalized_value <= '0;
                o_saturated        <= 1'b0;
            end else if (r_neg) begin
                if (r_quo > 74'h80000000) begin
                    o_normalized_value <= 32'sh80000000;
                    o_saturated        <= 1'b1;
                end else begin
                    o_normalized_value <= 32'(-r_quo[31:0]);
                    o_saturated        <= 1'b0;
                end
            end else begin
                if (r_quo > 74'h7FFFFFFF) begin
                    o_normalized_value <= 32'sh7FFFFFFF;
                    o_saturated        <= 1'b1;
                end else begin
                    o_normalized_value <= r_quo[31:0];
                    o_saturated        <= 1'b0;
                end
            end
        end
    end
    assign o_done = r_done;
endmodule

[hw/rtl/csr_spmv_normalized.sv]
// ----------------------------------------------------------------------------
// csr_spmv_normalized
// Normalized sparse matrix-vector product over a CSR matrix.
// ----------------------------------------------------------------------------
// Channel   Signals                                      Handshake
// command   i_operation i_index i_pointer i_column ...   start while !busy
// result    o_normalized_value o_total_sum o_zero_sum    o_valid, one cycle
//
// Loads are written when accepted; busy stays low. Compute reads the row
// pointers, nonzeros and vector entries in turn, set by the single read port
// of each store. A read runs the restoring divider, one quotient bit a cycle.
// Reset clears the controller and the total. The receiver cannot stall.
module csr_spmv_normalized
    import csrspmv_pkg::*;
#(
    parameter int MAX_ROWS     = MAX_ROWS_DEF,
    parameter int MAX_NONZEROS = MAX_NONZEROS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         i_operation,
    input  logic [12:0]        i_index,
    input  logic [12:0]        i_pointer,
    input  logic [9:0]         i_column,
    input  logic signed [15:0] i_value,
    input  logic [10:0]        i_row_count,
    output logic               o_valid,
    output logic signed [31:0] o_normalized_value,
    output logic signed [57:0] o_total_sum,
    output logic               o_zero_sum,
    output logic               o_saturated
);
`include "assert_macros.svh"
    t_cmd    cmd;
    t_status status;
    logic    accept;
    assign accept = start && !busy;

    csrspmv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (accept),
        .i_operation(i_operation),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_busy     (busy)
    );

    csrspmv_dp #(.MAX_ROWS(MAX_ROWS), .MAX_NONZEROS(MAX_NONZEROS)) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_index           (i_index),
        .i_pointer         (i_pointer),
        .i_column          (i_column),
        .i_value           (i_value),
        .i_row_count       (i_row_count),
        .o_status          (status),
        .o_done            (o_valid),
        .o_normalized_value(o_normalized_value),
        .o_total_sum       (o_total_sum),
        .o_zero_sum        (o_zero_sum),
        .o_saturated       (o_saturated)
    );

    `ASSERT_NEXT(a_load_no_busy, i_clk, i_rst_n,
        accept && (i_operation < OP_COMPUTE), !busy)
    `ASSERT_IMP(a_valid_idle, i_clk, i_rst_n, o_valid, !busy)
    `ASSERT_IMP(a_zero_flag, i_clk, i_rst_n, o_valid && o_zero_sum, o_normalized_value == 32'sd0)
endmodule
